// File: rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

  // Operation codes carried with each input transaction.
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Character codes with a special meaning.
  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0] CHAR_BLANK     = 8'h20;

  // Register indexes on the configuration port.
  localparam logic REG_TEXT_ATTR  = 1'b0;
  localparam logic REG_CLEAR_ATTR = 1'b1;

  // Reset values.
  localparam logic [7:0] TEXT_ATTR_RST   = 8'h0f;
  localparam logic [7:0] CLEAR_ATTR_RST  = 8'h02;
  localparam logic [7:0] SCREEN_ATTR_RST = 8'h02;

  // Configuration registers handed to the core.
  typedef struct packed {
    logic [7:0] text_attr;
    logic [7:0] clear_attr;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    logic        did_scroll;
    logic [10:0] cursor_pos;
    logic [7:0]  cell_attr;
    logic [7:0]  cell_char;
  } result_t;

endpackage

// File: rtl/tcw_cfg.sv
// Configuration register file behind the APB-style port.
module tcw_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tcw_pkg::cfg_t     cfg
);
  import tcw_pkg::*;

  logic wr_en;

  // A write completes in the access phase; the port never waits.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes, decoded on the word address bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_attr  <= TEXT_ATTR_RST;
      cfg.clear_attr <= CLEAR_ATTR_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_TEXT_ATTR:  cfg.text_attr  <= pwdata[7:0];
        REG_CLEAR_ATTR: cfg.clear_attr <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    unique case (paddr[2])
      REG_TEXT_ATTR:  prdata = {24'd0, cfg.text_attr};
      REG_CLEAR_ATTR: prdata = {24'd0, cfg.clear_attr};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/tcw_core.sv
// Screen memories, cursor and the sequencer that updates them.
module tcw_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  tcw_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [7:0]         char_code,
  input  logic [10:0]        cell_index,
  output logic               res_valid,
  input  logic               res_ready,
  output tcw_pkg::result_t   res
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_READ, S_SCROLL, S_CLEAR, S_RESULT
  } state_t;

  state_t        state;
  logic [AW-1:0] ptr;
  logic [AW-1:0] cursor;
  logic [CW-1:0] col;
  logic          pend_v;
  logic [AW-1:0] pend_addr;
  logic          pend_blank;
  logic          rd_ok;
  logic [7:0]    res_char;
  logic [7:0]    res_attr;
  logic          res_scroll;

  // Screen storage: one character and one attribute per cell.
  logic [7:0]    chars [CELLS];
  logic [7:0]    attrs [CELLS];
  logic [7:0]    rd_char;
  logic [7:0]    rd_attr;

  logic          ch_we;
  logic          at_we;
  logic [AW-1:0] waddr;
  logic [7:0]    ch_wdata;
  logic [7:0]    at_wdata;
  logic          ren;
  logic [AW-1:0] raddr;

  logic          accept;
  logic          ptr_last;
  logic [AW:0]   cur_inc;
  logic [AW:0]   nl_cur;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ptr_last = (ptr == AW'(CELLS - 1));
  assign cur_inc  = {1'b0, cursor} + (AW+1)'(1);
  assign nl_cur   = {1'b0, cursor} - (AW+1)'(col) + (AW+1)'(COLUMNS);

  // Result seen by the output buffer.
  assign res_valid      = (state == S_RESULT);
  assign res.cell_char  = res_char;
  assign res.cell_attr  = res_attr;
  assign res.cursor_pos = 11'(cursor);
  assign res.did_scroll = res_scroll;

  // Memory port control for every phase of the sequencer.
  always_comb begin
    ch_we    = 1'b0;
    at_we    = 1'b0;
    waddr    = ptr;
    ch_wdata = CHAR_BLANK;
    at_wdata = cfg.clear_attr;
    ren      = 1'b0;
    raddr    = ptr;
    if (pend_v) begin
      ch_we    = 1'b1;
      waddr    = pend_addr;
      ch_wdata = pend_blank ? CHAR_BLANK : rd_char;
    end
    unique case (state)
      S_INIT: begin
        ch_we    = 1'b1;
        at_we    = 1'b1;
        at_wdata = SCREEN_ATTR_RST;
      end
      S_CLEAR: begin
        ch_we = 1'b1;
        at_we = 1'b1;
      end
      S_IDLE: begin
        if (accept && op == OP_PUT) begin
          if (char_code == CHAR_BACKSPACE) begin
            ch_we = (cursor != '0);
            waddr = cursor - AW'(1);
          end else if (char_code != CHAR_NUL && char_code != CHAR_NEWLINE) begin
            ch_we    = 1'b1;
            at_we    = 1'b1;
            waddr    = cursor;
            ch_wdata = char_code;
            at_wdata = cfg.text_attr;
          end
        end else if (accept && op == OP_READ) begin
          ren   = 1'b1;
          raddr = AW'(cell_index);
        end
      end
      S_SCROLL: begin
        ren   = (ptr < AW'(CELLS - COLUMNS));
        raddr = ptr + AW'(COLUMNS);
      end
      default: ;
    endcase
  end

  // Character memory, registered read.
  always_ff @(posedge clk) begin
    if (ch_we) begin
      chars[waddr] <= ch_wdata;
    end
    if (ren) begin
      rd_char <= chars[raddr];
    end
  end

  // Attribute memory, registered read.
  always_ff @(posedge clk) begin
    if (at_we) begin
      attrs[waddr] <= at_wdata;
    end
    if (ren) begin
      rd_attr <= attrs[raddr];
    end
  end

  // Sequencer: state, cursor, sweep pointer and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      ptr    <= '0;
      cursor <= AW'(COLUMNS);
      col    <= '0;
      pend_v <= 1'b0;
    end else begin
      pend_v <= 1'b0;
      unique case (state)
        S_INIT: begin
          ptr <= ptr + AW'(1);
          if (ptr_last) begin
            ptr   <= '0;
            state <= S_IDLE;
          end
        end
        S_CLEAR: begin
          ptr <= ptr + AW'(1);
          if (ptr_last) begin
            ptr   <= '0;
            state <= S_RESULT;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_char   <= 8'd0;
            res_attr   <= 8'd0;
            res_scroll <= 1'b0;
            rd_ok      <= (32'(cell_index) < 32'(CELLS));
            ptr        <= '0;
            state      <= S_RESULT;
            unique case (op)
              OP_PUT: begin
                priority if (char_code == CHAR_NUL) begin
                  state <= S_RESULT;
                end else if (char_code == CHAR_NEWLINE) begin
                  if (nl_cur >= (AW+1)'(CELLS)) begin
                    state <= S_SCROLL;
                  end else begin
                    cursor <= AW'(nl_cur);
                    col    <= '0;
                  end
                end else if (char_code == CHAR_BACKSPACE) begin
                  if (cursor != '0) begin
                    cursor <= cursor - AW'(1);
                    col    <= (col == '0) ? CW'(COLUMNS - 1) : col - CW'(1);
                  end
                end else begin
                  if (cur_inc == (AW+1)'(CELLS)) begin
                    state <= S_SCROLL;
                  end else begin
                    cursor <= AW'(cur_inc);
                    col    <= (col == CW'(COLUMNS - 1)) ? '0 : col + CW'(1);
                  end
                end
              end
              OP_CLEAR: state <= S_CLEAR;
              OP_READ:  state <= S_READ;
              default:  state <= S_RESULT;
            endcase
          end
        end
        S_READ: begin
          res_char <= rd_ok ? rd_char : 8'd0;
          res_attr <= rd_ok ? rd_attr : 8'd0;
          state    <= S_RESULT;
        end
        S_SCROLL: begin
          // Read row below, write it in the following cycle into the row above.
          pend_v     <= 1'b1;
          pend_addr  <= ptr;
          pend_blank <= (ptr >= AW'(CELLS - COLUMNS));
          ptr        <= ptr + AW'(1);
          if (ptr_last) begin
            ptr        <= '0;
            cursor     <= AW'(CELLS - COLUMNS);
            col        <= '0;
            res_scroll <= 1'b1;
            state      <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A delayed scroll write only follows a scroll cycle.
  a_pend_after_scroll: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> $past(state) == S_SCROLL)
    else $error("scroll write outside a scroll pass");

  // The scroll read never hits the cell being written back.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (pend_v && ren) |-> raddr != pend_addr)
    else $error("scroll read and write collide");

  // Cursor and column stay on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RESULT |-> cursor < AW'(CELLS) && col < CW'(COLUMNS - 1) + CW'(1))
    else $error("cursor off the screen");

  // Items are only taken outside the sweeps.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> $past(state) == S_IDLE && state != S_INIT)
    else $error("item taken during a sweep");
`endif

endmodule

// File: rtl/tcw_obuf.sv
// Output register that holds a result until the master side takes it.
module tcw_obuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  output logic               res_ready,
  input  tcw_pkg::result_t   res,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata
);
  import tcw_pkg::*;

  result_t held;

  assign res_ready = !m_tvalid || m_tready;
  assign m_tdata   = {4'd0, held};

  // Load a new result whenever the slot is free or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload holds while a transaction waits.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      held <= res;
    end
  end

endmodule

// File: rtl/text_console_writer.sv
// Top level of the text console writer.
// A put or unused op goes to S_RESULT, then the output buffer; a read passes S_READ first,
// a clear an S_CLEAR sweep of all CELLS, a scrolling put the one-cell-a-cycle copy pass.
// The next item is taken only once the result is handed to the output buffer.
// Reset: synchronous; registers return to defaults and a clearing pass over all CELLS fills
// the screen before s_tready rises; configuration is taken meanwhile.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index, [23:19] zero
  input  logic [1:0]  s_tuser,   // [1:0] op
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [7:0] cell_char, [15:8] cell_attr,
                                 // [26:16] cursor_pos, [27] did_scroll, [31:28] zero
);
  import tcw_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_valid;
  logic    res_ready;

  tcw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcw_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .op         (s_tuser),
    .char_code  (s_tdata[7:0]),
    .cell_index (s_tdata[18:8]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  tcw_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
